// File: rtl/arpc_pkg.sv
package arpc_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_QUEUE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        KIND_REPLY   = 3'd0,
        KIND_REQUEST = 3'd1,
        KIND_FORWARD = 3'd2,
        KIND_UNREACH = 3'd3,
        KIND_DROPPED = 3'd4
    } kind_e;

    typedef enum logic [1:0] {
        REG_AGE_LIMIT = 2'd0,
        REG_MAX_REQ   = 2'd1,
        REG_RETRY     = 2'd2
    } reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MSCAN,
        ST_MDONE,
        ST_RSCAN,
        ST_QACT,
        ST_HRD,
        ST_HOUT,
        ST_FIN
    } st_e;

    localparam int RESULT_CAP  = 32;
    localparam int CAP_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] AGE_RESET   = 8'd15;
    localparam logic [2:0] MAXREQ_RESET = 3'd5;
    localparam logic [3:0] RETRY_RESET = 4'd1;

    typedef struct packed {
        cmd_e         cmd;
        logic [31:0]  ip;
        logic [47:0]  mac;
        logic [3:0]   iface;
        logic [9:0]   handle;
    } item_t;

    typedef struct packed {
        kind_e        kind;
        logic         hit;
        logic [31:0]  ip;
        logic [47:0]  mac;
        logic [3:0]   iface;
        logic [9:0]   handle;
    } result_t;

    typedef struct packed {
        logic [7:0] age_limit;
        logic [2:0] max_req;
        logic [3:0] retry;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        logic  ready;
    } hs_t;

endpackage

// File: rtl/arpc_if.sv
interface arpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [3:0]  iface_id;
    logic [9:0]  packet_handle;

    modport source (output valid, command, ip_addr, mac_addr, iface_id, packet_handle,
                    input ready);
    modport sink (input valid, command, ip_addr, mac_addr, iface_id, packet_handle,
                  output ready);
endinterface

interface arpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        hit;
    logic [31:0] out_ip;
    logic [47:0] out_mac;
    logic [3:0]  out_iface;
    logic [9:0]  out_handle;
    logic        last;

    modport source (output valid, kind, hit, out_ip, out_mac, out_iface, out_handle, last,
                    input ready);
    modport sink (input valid, kind, hit, out_ip, out_mac, out_iface, out_handle, last,
                  output ready);
endinterface

interface arpc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/arpc_front.sv
module arpc_front (
    input  logic                clk,
    input  logic                rst_n,
    arpc_in_if.sink             in_ch,
    output arpc_pkg::item_t     push_item,
    output logic                push_valid,
    input  logic                push_ready
);

    logic            v_reg, v_next;
    arpc_pkg::item_t item_reg, item_next;
    logic            take;

    assign in_ch.ready = !v_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;

    // decode the word into an internal command
    always_comb
    begin
        item_next = item_reg;
        if (take)
        begin
            item_next.cmd    = arpc_pkg::cmd_e'(in_ch.command);
            item_next.ip     = in_ch.ip_addr;
            item_next.mac    = in_ch.mac_addr;
            item_next.iface  = in_ch.iface_id;
            item_next.handle = in_ch.packet_handle;
        end
        v_next = take || (v_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_item  = item_reg;
    assign push_valid = v_reg;

endmodule

// File: rtl/arpc_fifo.sv
module arpc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  arpc_pkg::item_t  wr_item,
    input  logic             wr_valid,
    output logic             wr_ready,
    output arpc_pkg::item_t  rd_item,
    output logic             rd_valid,
    input  logic             rd_ready
);

    localparam int D  = arpc_pkg::QUEUE_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    arpc_pkg::item_t  slot_reg [D];
    logic [AW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CW'(D));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == AW'(D - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == AW'(D - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_item;
    end

endmodule

// File: rtl/arpc_back.sv
module arpc_back #(
    parameter int MAP_ENTRIES  = 32,
    parameter int PENDING_REQS = 8,
    parameter int PKTS_PER_REQ = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  arpc_pkg::cfg_t   cfg,
    input  arpc_pkg::item_t  cmd_item,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    arpc_out_if.source       out_ch
);

    localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int MCW = $clog2(MAP_ENTRIES + 1);
    localparam int RAW = (PENDING_REQS > 1) ? $clog2(PENDING_REQS) : 1;
    localparam int RCW = $clog2(PENDING_REQS + 1);
    localparam int PCW = $clog2(PKTS_PER_REQ + 1);
    localparam int HD  = PENDING_REQS * PKTS_PER_REQ;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int CAPW = arpc_pkg::CAP_W;

    arpc_pkg::st_e    state_reg, state_next;
    arpc_pkg::item_t  cur_reg;

    // mapping table
    logic [31:0]      map_ip_mem    [MAP_ENTRIES];
    logic [47:0]      map_mac_mem   [MAP_ENTRIES];
    logic [15:0]      map_added_mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] map_valid_reg;
    logic [31:0]      rd_ip_reg;
    logic [47:0]      rd_mac_reg;
    logic [15:0]      rd_added_reg;
    logic [MCW-1:0]   m_cnt_reg;
    logic             cmp_vld_reg;
    logic [MAW-1:0]   cmp_idx_reg;
    logic             fm_found_reg, ff_found_reg;
    logic [MAW-1:0]   fm_idx_reg, ff_idx_reg;
    logic [47:0]      hit_mac_reg;
    logic [15:0]      now_reg;

    // pending requests
    logic [PENDING_REQS-1:0] req_valid_reg;
    logic [31:0]      req_ip_reg    [PENDING_REQS];
    logic [3:0]       req_iface_reg [PENDING_REQS];
    logic [2:0]       req_tries_reg [PENDING_REQS];
    logic [15:0]      req_sent_reg  [PENDING_REQS];
    logic [PCW-1:0]   req_count_reg [PENDING_REQS];
    logic [RCW-1:0]   r_cnt_reg;
    logic             qm_found_reg, qf_found_reg;
    logic [RAW-1:0]   qm_idx_reg, qf_idx_reg;
    logic [PCW-1:0]   k_reg;
    logic [9:0]       handle_mem [HD];
    logic [9:0]       rd_handle_reg;

    // result staging
    logic [CAPW-1:0]  n_reg;
    logic             hold_valid_reg;
    arpc_pkg::result_t hold_reg;
    logic             out_valid_reg;
    arpc_pkg::result_t out_data_reg;
    logic             out_last_reg;

    logic             deq, adv, em_req, em_fire, em_ok, out_free, capped;
    arpc_pkg::result_t em_data;

    logic [RAW-1:0]   r_idx;
    logic             r_in, r_v, r_ip_eq, r_if_eq, r_due, r_giveup, m_match, m_aged;
    logic [MAW-1:0]   wr_slot;
    logic [HAW-1:0]   q_addr;

    assign r_idx    = r_cnt_reg[RAW-1:0];
    assign r_in     = (r_cnt_reg < RCW'(PENDING_REQS));
    assign r_v      = r_in && req_valid_reg[r_idx];
    assign r_ip_eq  = (req_ip_reg[r_idx] == cur_reg.ip);
    assign r_if_eq  = (req_iface_reg[r_idx] == cur_reg.iface);
    assign r_due    = ((now_reg - req_sent_reg[r_idx]) >= {12'd0, cfg.retry});
    assign r_giveup = (req_tries_reg[r_idx] >= cfg.max_req);
    assign m_match  = map_valid_reg[cmp_idx_reg] && (rd_ip_reg == cur_reg.ip);
    assign m_aged   = map_valid_reg[cmp_idx_reg] && ((now_reg - rd_added_reg) > {8'd0, cfg.age_limit});
    assign wr_slot  = fm_found_reg ? fm_idx_reg : ff_idx_reg;
    assign q_addr   = qm_found_reg
                    ? HAW'(int'(qm_idx_reg) * PKTS_PER_REQ + int'(req_count_reg[qm_idx_reg]))
                    : HAW'(int'(qf_idx_reg) * PKTS_PER_REQ);

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign capped    = (n_reg >= CAPW'(arpc_pkg::RESULT_CAP));
    assign em_ok     = capped || !hold_valid_reg || out_free;
    assign em_fire   = em_req && adv && !capped;
    assign cmd_ready = deq;

    // actions per state
    always_comb
    begin
        deq     = 1'b0;
        adv     = 1'b1;
        em_req  = 1'b0;
        em_data = '0;
        case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                deq = cmd_valid;
            end
            arpc_pkg::ST_MDONE:
            begin
                if (cur_reg.cmd == arpc_pkg::CMD_LOOKUP)
                begin
                    em_req       = 1'b1;
                    em_data.kind = arpc_pkg::KIND_REPLY;
                    em_data.hit  = fm_found_reg;
                    em_data.ip   = cur_reg.ip;
                    em_data.mac  = fm_found_reg ? hit_mac_reg : 48'd0;
                    adv          = em_ok;
                end
            end
            arpc_pkg::ST_RSCAN:
            begin
                if (cur_reg.cmd == arpc_pkg::CMD_TICK && r_v && r_due && !r_giveup)
                begin
                    em_req        = 1'b1;
                    em_data.kind  = arpc_pkg::KIND_REQUEST;
                    em_data.ip    = req_ip_reg[r_idx];
                    em_data.iface = req_iface_reg[r_idx];
                    adv           = em_ok;
                end
            end
            arpc_pkg::ST_HOUT:
            begin
                em_req         = 1'b1;
                em_data.iface  = req_iface_reg[r_idx];
                em_data.handle = rd_handle_reg;
                if (cur_reg.cmd == arpc_pkg::CMD_INSERT)
                begin
                    em_data.kind = arpc_pkg::KIND_FORWARD;
                    em_data.ip   = cur_reg.ip;
                    em_data.mac  = cur_reg.mac;
                end
                else
                begin
                    em_data.kind = arpc_pkg::KIND_UNREACH;
                    em_data.ip   = req_ip_reg[r_idx];
                end
                adv = em_ok;
            end
            arpc_pkg::ST_QACT:
            begin
                em_data.ip = cur_reg.ip;
                if (qm_found_reg)
                begin
                    if (req_count_reg[qm_idx_reg] >= PCW'(PKTS_PER_REQ))
                    begin
                        em_req         = 1'b1;
                        em_data.kind   = arpc_pkg::KIND_DROPPED;
                        em_data.handle = cur_reg.handle;
                    end
                end
                else if (qf_found_reg)
                begin
                    em_req        = 1'b1;
                    em_data.kind  = arpc_pkg::KIND_REQUEST;
                    em_data.iface = cur_reg.iface;
                end
                else
                begin
                    em_req         = 1'b1;
                    em_data.kind   = arpc_pkg::KIND_DROPPED;
                    em_data.handle = cur_reg.handle;
                end
                adv = !em_req || em_ok;
            end
            arpc_pkg::ST_FIN:
            begin
                adv = !hold_valid_reg || out_free;
            end
            default:
            begin
                adv = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = (cmd_item.cmd == arpc_pkg::CMD_QUEUE)
                               ? arpc_pkg::ST_RSCAN : arpc_pkg::ST_MSCAN;
            end
            arpc_pkg::ST_MSCAN:
            begin
                if (m_cnt_reg == MCW'(MAP_ENTRIES))
                    state_next = arpc_pkg::ST_MDONE;
            end
            arpc_pkg::ST_MDONE:
            begin
                if (adv)
                    state_next = (cur_reg.cmd == arpc_pkg::CMD_LOOKUP)
                               ? arpc_pkg::ST_FIN : arpc_pkg::ST_RSCAN;
            end
            arpc_pkg::ST_RSCAN:
            begin
                if (!r_in)
                    state_next = (cur_reg.cmd == arpc_pkg::CMD_QUEUE)
                               ? arpc_pkg::ST_QACT : arpc_pkg::ST_FIN;
                else if (cur_reg.cmd == arpc_pkg::CMD_INSERT && r_v && r_ip_eq)
                    state_next = arpc_pkg::ST_HRD;
                else if (cur_reg.cmd == arpc_pkg::CMD_TICK && r_v && r_due && r_giveup)
                    state_next = arpc_pkg::ST_HRD;
            end
            arpc_pkg::ST_HRD:
            begin
                state_next = arpc_pkg::ST_HOUT;
            end
            arpc_pkg::ST_HOUT:
            begin
                if (adv)
                    state_next = (k_reg + 1'b1 >= req_count_reg[r_idx])
                               ? arpc_pkg::ST_RSCAN : arpc_pkg::ST_HRD;
            end
            arpc_pkg::ST_QACT:
            begin
                if (adv)
                    state_next = arpc_pkg::ST_FIN;
            end
            arpc_pkg::ST_FIN:
            begin
                if (adv)
                    state_next = arpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arpc_pkg::ST_IDLE;
            map_valid_reg  <= '0;
            req_valid_reg  <= '0;
            now_reg        <= '0;
            m_cnt_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            r_cnt_reg      <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fm_found_reg   <= 1'b0;
            ff_found_reg   <= 1'b0;
            qm_found_reg   <= 1'b0;
            qf_found_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (em_fire)
            begin
                hold_valid_reg <= 1'b1;
                n_reg          <= n_reg + 1'b1;
                if (hold_valid_reg)
                    out_valid_reg <= 1'b1;
            end
            case (state_reg)
                arpc_pkg::ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        n_reg        <= '0;
                        m_cnt_reg    <= '0;
                        cmp_vld_reg  <= 1'b0;
                        r_cnt_reg    <= '0;
                        fm_found_reg <= 1'b0;
                        ff_found_reg <= 1'b0;
                        qm_found_reg <= 1'b0;
                        qf_found_reg <= 1'b0;
                        if (cmd_item.cmd == arpc_pkg::CMD_TICK)
                            now_reg <= now_reg + 1'b1;
                    end
                end
                arpc_pkg::ST_MSCAN:
                begin
                    if (m_cnt_reg != MCW'(MAP_ENTRIES))
                        m_cnt_reg <= m_cnt_reg + 1'b1;
                    cmp_vld_reg <= (m_cnt_reg != MCW'(MAP_ENTRIES));
                    if (cmp_vld_reg)
                    begin
                        if (cur_reg.cmd == arpc_pkg::CMD_TICK)
                        begin
                            if (m_aged)
                                map_valid_reg[cmp_idx_reg] <= 1'b0;
                        end
                        else
                        begin
                            if (m_match && !fm_found_reg)
                                fm_found_reg <= 1'b1;
                            if (!map_valid_reg[cmp_idx_reg] && !ff_found_reg)
                                ff_found_reg <= 1'b1;
                        end
                    end
                end
                arpc_pkg::ST_MDONE:
                begin
                    if (cur_reg.cmd == arpc_pkg::CMD_INSERT && (fm_found_reg || ff_found_reg))
                        map_valid_reg[wr_slot] <= 1'b1;
                end
                arpc_pkg::ST_RSCAN:
                begin
                    if (r_in)
                    begin
                        case (cur_reg.cmd)
                            arpc_pkg::CMD_QUEUE:
                            begin
                                if (r_v && r_ip_eq && r_if_eq && !qm_found_reg)
                                    qm_found_reg <= 1'b1;
                                if (!r_v && !qf_found_reg)
                                    qf_found_reg <= 1'b1;
                                r_cnt_reg <= r_cnt_reg + 1'b1;
                            end
                            arpc_pkg::CMD_INSERT:
                            begin
                                if (r_v && r_ip_eq)
                                    k_reg <= '0;
                                else
                                    r_cnt_reg <= r_cnt_reg + 1'b1;
                            end
                            arpc_pkg::CMD_TICK:
                            begin
                                if (r_v && r_due && r_giveup)
                                    k_reg <= '0;
                                else if (adv)
                                    r_cnt_reg <= r_cnt_reg + 1'b1;
                            end
                            default:
                            begin
                                r_cnt_reg <= r_cnt_reg + 1'b1;
                            end
                        endcase
                    end
                end
                arpc_pkg::ST_HOUT:
                begin
                    if (adv)
                    begin
                        if (k_reg + 1'b1 >= req_count_reg[r_idx])
                        begin
                            req_valid_reg[r_idx] <= 1'b0;
                            r_cnt_reg            <= r_cnt_reg + 1'b1;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                arpc_pkg::ST_QACT:
                begin
                    if (adv && !qm_found_reg && qf_found_reg)
                        req_valid_reg[qf_idx_reg] <= 1'b1;
                end
                arpc_pkg::ST_FIN:
                begin
                    if (adv && hold_valid_reg)
                    begin
                        hold_valid_reg <= 1'b0;
                        out_valid_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (deq)
            cur_reg <= cmd_item;
        if (state_reg == arpc_pkg::ST_MSCAN)
            cmp_idx_reg <= m_cnt_reg[MAW-1:0];
        if (state_reg == arpc_pkg::ST_MSCAN && cmp_vld_reg)
        begin
            if (m_match && !fm_found_reg)
            begin
                fm_idx_reg  <= cmp_idx_reg;
                hit_mac_reg <= rd_mac_reg;
            end
            if (!map_valid_reg[cmp_idx_reg] && !ff_found_reg)
                ff_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == arpc_pkg::ST_RSCAN && r_in && cur_reg.cmd == arpc_pkg::CMD_QUEUE)
        begin
            if (r_v && r_ip_eq && r_if_eq && !qm_found_reg)
                qm_idx_reg <= r_idx;
            if (!r_v && !qf_found_reg)
                qf_idx_reg <= r_idx;
        end
        if (state_reg == arpc_pkg::ST_RSCAN && em_req && adv)
        begin
            req_tries_reg[r_idx] <= req_tries_reg[r_idx] + 1'b1;
            req_sent_reg[r_idx]  <= now_reg;
        end
        if (state_reg == arpc_pkg::ST_QACT && adv)
        begin
            if (qm_found_reg)
            begin
                if (!em_req)
                    req_count_reg[qm_idx_reg] <= req_count_reg[qm_idx_reg] + 1'b1;
            end
            else if (qf_found_reg)
            begin
                req_ip_reg[qf_idx_reg]    <= cur_reg.ip;
                req_iface_reg[qf_idx_reg] <= cur_reg.iface;
                req_tries_reg[qf_idx_reg] <= 3'd1;
                req_sent_reg[qf_idx_reg]  <= now_reg;
                req_count_reg[qf_idx_reg] <= PCW'(1);
            end
        end
        if (em_fire)
        begin
            hold_reg <= em_data;
            if (hold_valid_reg)
            begin
                out_data_reg <= hold_reg;
                out_last_reg <= 1'b0;
            end
        end
        if (state_reg == arpc_pkg::ST_FIN && adv && hold_valid_reg)
        begin
            out_data_reg <= hold_reg;
            out_last_reg <= 1'b1;
        end
    end

    // mapping table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        rd_ip_reg    <= map_ip_mem[m_cnt_reg[MAW-1:0]];
        rd_mac_reg   <= map_mac_mem[m_cnt_reg[MAW-1:0]];
        rd_added_reg <= map_added_mem[m_cnt_reg[MAW-1:0]];
        if (state_reg == arpc_pkg::ST_MDONE && cur_reg.cmd == arpc_pkg::CMD_INSERT
            && (fm_found_reg || ff_found_reg))
        begin
            map_ip_mem[wr_slot]    <= cur_reg.ip;
            map_mac_mem[wr_slot]   <= cur_reg.mac;
            map_added_mem[wr_slot] <= now_reg;
        end
    end

    // parked handle memory
    always_ff @(posedge clk)
    begin
        rd_handle_reg <= handle_mem[HAW'(int'(r_idx) * PKTS_PER_REQ + int'(k_reg))];
        if (state_reg == arpc_pkg::ST_QACT && adv && !em_req)
            handle_mem[q_addr] <= cur_reg.handle;
        else if (state_reg == arpc_pkg::ST_QACT && adv && !qm_found_reg && qf_found_reg)
            handle_mem[q_addr] <= cur_reg.handle;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_data_reg.kind;
    assign out_ch.hit        = out_data_reg.hit;
    assign out_ch.out_ip     = out_data_reg.ip;
    assign out_ch.out_mac    = out_data_reg.mac;
    assign out_ch.out_iface  = out_data_reg.iface;
    assign out_ch.out_handle = out_data_reg.handle;
    assign out_ch.last       = out_last_reg;

endmodule

// File: rtl/arp_cache_with_pending_queue_unit.sv
// channel   dir  payload                                           word
// in_ch     in   command ip_addr mac_addr iface_id packet_handle   one command
// out_ch    out  kind hit out_ip out_mac out_iface out_handle last one result
// cfg_ch    in   index data                                        one register write
//
// lookup: one pass over the map table through its single read port
// insert and tick: a map table pass, then a pending request pass; each released handle is read, then emitted
// queue: no map table pass, one pending request examined per cycle
// rst_n clears valid bits, counters and the clock of seconds; no clearing pass
// a stalled out_ch holds the engine, while the front stage and queue still take words until they fill
module arp_cache_with_pending_queue_unit #(
    parameter int MAP_ENTRIES  = 32,
    parameter int PENDING_REQS = 8,
    parameter int PKTS_PER_REQ = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    arpc_in_if.sink     in_ch,
    arpc_out_if.source  out_ch,
    arpc_cfg_if.sink    cfg_ch
);

    arpc_pkg::cfg_t   cfg_reg, cfg_next;
    arpc_pkg::item_t  fr_item, q_item;
    logic             fr_valid, fr_ready, q_valid, q_ready;

    // registers always accept a write
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (arpc_pkg::reg_e'(cfg_ch.index))
                arpc_pkg::REG_AGE_LIMIT: cfg_next.age_limit = cfg_ch.data;
                arpc_pkg::REG_MAX_REQ:   cfg_next.max_req   = cfg_ch.data[2:0];
                arpc_pkg::REG_RETRY:     cfg_next.retry     = cfg_ch.data[3:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.age_limit <= arpc_pkg::AGE_RESET;
            cfg_reg.max_req   <= arpc_pkg::MAXREQ_RESET;
            cfg_reg.retry     <= arpc_pkg::RETRY_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // front: take and decode commands
    arpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_item  (fr_item),
        .push_valid (fr_valid),
        .push_ready (fr_ready)
    );

    // short queue between front and engine
    arpc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (fr_item),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    // back: table scans, request handling and result staging
    arpc_back #(
        .MAP_ENTRIES  (MAP_ENTRIES),
        .PENDING_REQS (PENDING_REQS),
        .PKTS_PER_REQ (PKTS_PER_REQ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_item  (q_item),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .out_ch    (out_ch)
    );

endmodule

// File: tb/arp_cache_with_pending_queue_unit_tb.sv
module arp_cache_with_pending_queue_unit_tb;

    localparam int N_MAP    = 32;
    localparam int N_REQ    = 8;
    localparam int N_PKT    = 4;
    localparam int SETTLE   = 200;     // worst engine time for one command, with margin
    localparam int WATCHDOG = 20000;

    typedef struct {
        arpc_pkg::result_t r;
        logic              last;
    } word_t;

    typedef struct {
        arpc_pkg::reg_e idx;
        logic [7:0]     data;
    } cfg_word_t;

    logic clk;
    logic rst_n;

    arpc_in_if  in_ch ();
    arpc_out_if out_ch ();
    arpc_cfg_if cfg_ch ();

    arp_cache_with_pending_queue_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // clock, 10 units per period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor state: its own copy of the table, requests and clock
    // ---------------------------------------------------------------
    logic [7:0]  age_limit;
    logic [2:0]  max_req;
    logic [3:0]  retry_ivl;

    logic        mv      [N_MAP];
    logic [31:0] mip     [N_MAP];
    logic [47:0] mmac    [N_MAP];
    logic [15:0] madded  [N_MAP];

    logic        rv      [N_REQ];
    logic [31:0] rip     [N_REQ];
    logic [3:0]  rif     [N_REQ];
    logic [2:0]  rtries  [N_REQ];
    logic [15:0] rsent   [N_REQ];
    int          rcount  [N_REQ];
    logic [9:0]  parked  [N_REQ*N_PKT];
    logic [15:0] secs;

    word_t             expected_words[$];
    arpc_pkg::item_t   pending_cmds[$];
    cfg_word_t         pending_cfg[$];
    int                words_this_cmd;

    int          errors;
    int          cmds_sent;
    int          words_seen;
    int          cfg_writes;
    int          lookup_hits;
    int          forwards;
    int          unreach;
    int          drops;
    logic        idling_on;
    logic        fill_map_mode;
    logic [31:0] ip_pool [8];

    // one result word onto the expected store, honouring the per-command cap
    function automatic void add_word(arpc_pkg::kind_e k, logic h, logic [31:0] ip,
                                     logic [47:0] mac, logic [3:0] ifc, logic [9:0] hdl);
        word_t w;
        if (words_this_cmd >= arpc_pkg::RESULT_CAP)
            return;
        w.r.kind   = k;
        w.r.hit    = h;
        w.r.ip     = ip;
        w.r.mac    = mac;
        w.r.iface  = ifc;
        w.r.handle = hdl;
        w.last     = 1'b0;
        expected_words.push_back(w);
        words_this_cmd++;
    endfunction

    // resolves one accepted command against the predictor state
    function automatic void resolve_cmd(arpc_pkg::item_t it);
        int slot;
        logic found;
        logic [47:0] fmac;
        words_this_cmd = 0;
        slot = -1;
        case (it.cmd)
            arpc_pkg::CMD_LOOKUP:
            begin
                found = 1'b0;
                fmac  = '0;
                for (int i = 0; i < N_MAP; i++)
                    if (!found && mv[i] && mip[i] == it.ip)
                    begin
                        found = 1'b1;
                        fmac  = mmac[i];
                    end
                if (found)
                    lookup_hits++;
                add_word(arpc_pkg::KIND_REPLY, found, it.ip, fmac, 4'd0, 10'd0);
            end
            arpc_pkg::CMD_QUEUE:
            begin
                for (int i = 0; i < N_REQ; i++)
                    if (slot < 0 && rv[i] && rip[i] == it.ip && rif[i] == it.iface)
                        slot = i;
                if (slot >= 0)
                begin
                    if (rcount[slot] < N_PKT)
                    begin
                        parked[slot*N_PKT + rcount[slot]] = it.handle;
                        rcount[slot]++;
                    end
                    else
                    begin
                        add_word(arpc_pkg::KIND_DROPPED, 1'b0, it.ip, '0, 4'd0, it.handle);
                        drops++;
                    end
                end
                else
                begin
                    for (int i = 0; i < N_REQ; i++)
                        if (slot < 0 && !rv[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        add_word(arpc_pkg::KIND_DROPPED, 1'b0, it.ip, '0, 4'd0, it.handle);
                        drops++;
                    end
                    else
                    begin
                        rv[slot]     = 1'b1;
                        rip[slot]    = it.ip;
                        rif[slot]    = it.iface;
                        rtries[slot] = 3'd1;
                        rsent[slot]  = secs;
                        rcount[slot] = 1;
                        parked[slot*N_PKT] = it.handle;
                        add_word(arpc_pkg::KIND_REQUEST, 1'b0, it.ip, '0, it.iface, 10'd0);
                    end
                end
            end
            arpc_pkg::CMD_INSERT:
            begin
                for (int i = 0; i < N_MAP; i++)
                    if (slot < 0 && mv[i] && mip[i] == it.ip)
                        slot = i;
                for (int i = 0; i < N_MAP; i++)
                    if (slot < 0 && !mv[i])
                        slot = i;
                // full table: mapping is lost but waiting handles still go out
                if (slot >= 0)
                begin
                    mv[slot]     = 1'b1;
                    mip[slot]    = it.ip;
                    mmac[slot]   = it.mac;
                    madded[slot] = secs;
                end
                for (int i = 0; i < N_REQ; i++)
                    if (rv[i] && rip[i] == it.ip)
                    begin
                        for (int k = 0; k < rcount[i]; k++)
                        begin
                            add_word(arpc_pkg::KIND_FORWARD, 1'b0, it.ip, it.mac, rif[i],
                                     parked[i*N_PKT + k]);
                            forwards++;
                        end
                        rv[i]     = 1'b0;
                        rcount[i] = 0;
                    end
            end
            default:
            begin
                secs = secs + 16'd1;
                for (int i = 0; i < N_MAP; i++)
                    if (mv[i] && 16'(secs - madded[i]) > 16'(age_limit))
                        mv[i] = 1'b0;
                for (int i = 0; i < N_REQ; i++)
                    if (rv[i] && 16'(secs - rsent[i]) >= 16'(retry_ivl))
                    begin
                        if (rtries[i] >= max_req)
                        begin
                            for (int k = 0; k < rcount[i]; k++)
                            begin
                                add_word(arpc_pkg::KIND_UNREACH, 1'b0, rip[i], '0, rif[i],
                                         parked[i*N_PKT + k]);
                                unreach++;
                            end
                            rv[i]     = 1'b0;
                            rcount[i] = 0;
                        end
                        else
                        begin
                            add_word(arpc_pkg::KIND_REQUEST, 1'b0, rip[i], '0, rif[i], 10'd0);
                            rtries[i] = rtries[i] + 3'd1;
                            rsent[i]  = secs;
                        end
                    end
            end
        endcase
        if (words_this_cmd > 0)
            expected_words[expected_words.size()-1].last = 1'b1;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at word %0d: got %0h, wanted %0h", field, words_seen, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // command driver: sends pending_cmds on in_ch, random gaps between words
    // ---------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        arpc_pkg::item_t nxt;
        arpc_pkg::item_t took;
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.command       <= '0;
            in_ch.ip_addr       <= '0;
            in_ch.mac_addr      <= '0;
            in_ch.iface_id      <= '0;
            in_ch.packet_handle <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                took.cmd    = arpc_pkg::cmd_e'(in_ch.command);
                took.ip     = in_ch.ip_addr;
                took.mac    = in_ch.mac_addr;
                took.iface  = in_ch.iface_id;
                took.handle = in_ch.packet_handle;
                resolve_cmd(took);
                cmds_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    nxt = pending_cmds.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.command       <= nxt.cmd;
                    in_ch.ip_addr       <= nxt.ip;
                    in_ch.mac_addr      <= nxt.mac;
                    in_ch.iface_id      <= nxt.iface;
                    in_ch.packet_handle <= nxt.handle;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and receiver stalls
    // ---------------------------------------------------------------
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                    report("unexpected word ip", 64'(out_ch.out_ip), 64'd0);
                else
                begin
                    w = expected_words.pop_front();
                    if (out_ch.kind !== w.r.kind)
                        report("kind", out_ch.kind, w.r.kind);
                    if (out_ch.hit !== w.r.hit)
                        report("hit", out_ch.hit, w.r.hit);
                    if (out_ch.out_ip !== w.r.ip)
                        report("out_ip", out_ch.out_ip, w.r.ip);
                    if (out_ch.out_mac !== w.r.mac)
                        report("out_mac", out_ch.out_mac, w.r.mac);
                    if (out_ch.out_iface !== w.r.iface)
                        report("out_iface", out_ch.out_iface, w.r.iface);
                    if (out_ch.out_handle !== w.r.handle)
                        report("out_handle", out_ch.out_handle, w.r.handle);
                    if (out_ch.last !== w.last)
                        report("last", out_ch.last, w.last);
                end
                words_seen++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // register write driver; predictor takes the value on the handshake
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        cfg_word_t c;
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (arpc_pkg::reg_e'(cfg_ch.index))
                    arpc_pkg::REG_AGE_LIMIT: age_limit = cfg_ch.data;
                    arpc_pkg::REG_MAX_REQ:   max_req   = cfg_ch.data[2:0];
                    arpc_pkg::REG_RETRY:     retry_ivl = cfg_ch.data[3:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_cfg.size() > 0)
                begin
                    c = pending_cfg.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= c.idx;
                    cfg_ch.data  <= c.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: cycles with no handshake on any channel
    // ---------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("timeout with %0d words outstanding", expected_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic arpc_pkg::item_t mk(arpc_pkg::cmd_e c, logic [31:0] ip,
                                           logic [47:0] mac, logic [3:0] ifc,
                                           logic [9:0] hdl);
        arpc_pkg::item_t it;
        it.cmd    = c;
        it.ip     = ip;
        it.mac    = mac;
        it.iface  = ifc;
        it.handle = hdl;
        return it;
    endfunction

    // mostly a small ip pool and few interfaces, so requests fill and resolve
    function automatic arpc_pkg::item_t random_cmd();
        int r;
        arpc_pkg::cmd_e c;
        logic [31:0] ip;
        logic [3:0] ifc;
        r = $urandom_range(0, 99);
        if (fill_map_mode)
        begin
            if (r < 70)
                c = arpc_pkg::CMD_INSERT;
            else if (r < 85)
                c = arpc_pkg::CMD_LOOKUP;
            else if (r < 95)
                c = arpc_pkg::CMD_QUEUE;
            else
                c = arpc_pkg::CMD_TICK;
        end
        else
        begin
            if (r < 25)
                c = arpc_pkg::CMD_LOOKUP;
            else if (r < 60)
                c = arpc_pkg::CMD_QUEUE;
            else if (r < 78)
                c = arpc_pkg::CMD_INSERT;
            else
                c = arpc_pkg::CMD_TICK;
        end
        if (fill_map_mode && c == arpc_pkg::CMD_INSERT && $urandom_range(0, 3) != 0)
            ip = $urandom;
        else if ($urandom_range(0, 6) == 0)
            ip = $urandom;
        else
            ip = ip_pool[$urandom_range(0, 7)];
        ifc = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        return mk(c, ip, {16'($urandom), 32'($urandom)}, ifc, 10'($urandom));
    endfunction

    task automatic set_regs(logic [7:0] age, logic [2:0] mreq, logic [3:0] rty);
        pending_cfg.push_back('{arpc_pkg::REG_AGE_LIMIT, age});
        pending_cfg.push_back('{arpc_pkg::REG_MAX_REQ, {5'd0, mreq}});
        pending_cfg.push_back('{arpc_pkg::REG_RETRY, {4'd0, rty}});
        wait (pending_cfg.size() == 0 && !cfg_ch.valid);
        @(posedge clk);
    endtask

    // every result in, then room for a command that yields none to finish
    task automatic drain();
        wait (pending_cmds.size() == 0 && !in_ch.valid && expected_words.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_burst(int count);
        repeat (count) pending_cmds.push_back(random_cmd());
    endtask

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        errors = 0;
        cmds_sent = 0;
        words_seen = 0;
        cfg_writes = 0;
        lookup_hits = 0;
        forwards = 0;
        unreach = 0;
        drops = 0;
        quiet_cycles = 0;
        idling_on = 1'b1;
        fill_map_mode = 1'b0;
        age_limit = arpc_pkg::AGE_RESET;
        max_req   = arpc_pkg::MAXREQ_RESET;
        retry_ivl = arpc_pkg::RETRY_RESET;
        secs = '0;
        for (int i = 0; i < N_MAP; i++)
        begin
            mv[i] = 1'b0; mip[i] = '0; mmac[i] = '0; madded[i] = '0;
        end
        for (int i = 0; i < N_REQ; i++)
        begin
            rv[i] = 1'b0; rip[i] = '0; rif[i] = '0; rtries[i] = '0; rsent[i] = '0;
            rcount[i] = 0;
        end
        for (int i = 0; i < N_REQ*N_PKT; i++)
            parked[i] = '0;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            ip_pool[i] = $urandom;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed part under reset register values
        // miss, insert with no waiters, then hit
        pending_cmds.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'h0, '0, 4'd0, 10'd0));
        pending_cmds.push_back(mk(arpc_pkg::CMD_INSERT, 32'h0, '0, 4'd0, 10'd0));
        pending_cmds.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'h0, 48'h1, 4'd0, 10'd0));
        // new request, filled to the brim, one too many, then another interface
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'hF, 10'h3FF));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'hF, 10'h000));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'hF, 10'h155));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'hF, 10'h2AA));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'hF, 10'h123));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'hFFFF_FFFF, '0, 4'h0, 10'h001));
        pending_cmds.push_back(mk(arpc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  4'h0, 10'h0));
        // refresh of an existing mapping
        pending_cmds.push_back(mk(arpc_pkg::CMD_INSERT, 32'h0, 48'hA5A5_5A5A_0F0F,
                                  4'h0, 10'h0));
        pending_cmds.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'h0, '0, 4'd0, 10'd0));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'h0A00_0001, '0, 4'h3, 10'h077));
        // retries, then give up
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(mk(arpc_pkg::CMD_TICK, 32'h0, '0, 4'd0, 10'd0));
        // pending slots full, then no free slot
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'h0B00_0000 + i, '0,
                                      4'(i), 10'(i)));
        pending_cmds.push_back(mk(arpc_pkg::CMD_QUEUE, 32'h0C00_0000, '0, 4'h1, 10'h3FE));
        drain();

        // clean out the leftover requests with tight limits
        set_regs(8'd1, 3'd1, 4'd1);
        repeat (3) pending_cmds.push_back(mk(arpc_pkg::CMD_TICK, '0, '0, 4'd0, 10'd0));
        random_burst(50);
        drain();

        set_regs(8'd255, 3'd7, 4'd15);
        random_burst(50);
        // hold off until the block has answered everything so far
        wait (pending_cmds.size() == 0 && !in_ch.valid && expected_words.size() == 0);
        random_burst(40);
        drain();

        set_regs(8'd255, 3'd7, 4'd1);
        fill_map_mode = 1'b1;
        random_burst(70);
        drain();
        fill_map_mode = 1'b0;

        set_regs(8'd3, 3'd2, 4'd2);
        random_burst(70);
        drain();

        set_regs(8'd20, 3'd5, 4'd1);
        random_burst(60);
        // last stretch at full rate on both sides
        wait (pending_cmds.size() == 0);
        idling_on = 1'b0;
        random_burst(60);
        drain();

        $display("%0d commands, %0d result words, %0d register writes",
                 cmds_sent, words_seen, cfg_writes);
        $display("%0d lookup hits, %0d forwards, %0d unreachable, %0d drops",
                 lookup_hits, forwards, unreach, drops);
        if (errors == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/arpc_pkg.sv
rtl/arpc_if.sv
rtl/arpc_front.sv
rtl/arpc_fifo.sv
rtl/arpc_back.sv
rtl/arp_cache_with_pending_queue_unit.sv
tb/arp_cache_with_pending_queue_unit_tb.sv
